// ===== sv/lbt_pkg.sv =====
// shared constants and types for the light balance tracker stepper
package lbt_pkg;

   // configuration register indexes
   localparam logic [2:0] CSR_DIFF_THRESHOLD  = 3'd0;
   localparam logic [2:0] CSR_NIGHT_THRESHOLD = 3'd1;
   localparam logic [2:0] CSR_EMA_ALPHA       = 3'd2;
   localparam logic [2:0] CSR_X_MIN           = 3'd3;
   localparam logic [2:0] CSR_X_MAX           = 3'd4;
   localparam logic [2:0] CSR_Y_MIN           = 3'd5;
   localparam logic [2:0] CSR_Y_MAX           = 3'd6;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 13;

   // sensor offsets
   localparam logic [10:0] OFFS_LEFT   = 11'd22;
   localparam logic [10:0] OFFS_RIGHT  = 11'd20;
   localparam logic [10:0] OFFS_TOP    = 11'd90;
   localparam logic [10:0] OFFS_BOTTOM = 11'd170;

   // night rest position
   localparam logic [7:0] REST_X = 8'd90;
   localparam logic [7:0] REST_Y = 8'd20;

   // reset values
   localparam logic [9:0]  RST_DIFF_THRESHOLD  = 10'd5;
   localparam logic [12:0] RST_NIGHT_THRESHOLD = 13'd50;
   localparam logic [8:0]  RST_EMA_ALPHA       = 9'd26;
   localparam logic [7:0]  RST_X_MIN           = 8'd0;
   localparam logic [7:0]  RST_X_MAX           = 8'd90;
   localparam logic [7:0]  RST_Y_MIN           = 8'd50;
   localparam logic [7:0]  RST_Y_MAX           = 8'd90;
   localparam logic [7:0]  RST_PAN             = 8'd50;
   localparam logic [7:0]  RST_TILT            = 8'd90;

   // alpha full scale in q1.8
   localparam logic [8:0] ALPHA_ONE = 9'd256;

   typedef struct packed {
      logic [7:0] lo;
      logic [7:0] hi;
   } limits_type;

endpackage

// ===== sv/lbt_ema.sv =====
// exponential filter update for the bottom sensor, q10.8
module lbt_ema (
   input  logic [8:0]  alpha,
   input  logic [9:0]  sample,
   input  logic [17:0] filt,
   output logic [17:0] filt_next
);

   logic [8:0]  alpha_sat;
   logic [8:0]  alpha_inv;
   logic [18:0] prod_new;
   logic [26:0] prod_old;
   logic [19:0] sum;

   // a*b*256 is a multiple of 256, so the shift only touches the old term
   always_comb begin
      alpha_sat = (alpha > lbt_pkg::ALPHA_ONE) ? lbt_pkg::ALPHA_ONE : alpha;
      alpha_inv = lbt_pkg::ALPHA_ONE - alpha_sat;
      prod_new  = 19'(alpha_sat) * 19'(sample);
      prod_old  = 27'(alpha_inv) * 27'(filt);
      sum       = 20'(prod_new) + 20'(prod_old[26:8]);
      filt_next = sum[17:0];
   end

endmodule

// ===== sv/lbt_axis.sv =====
// one axis: deadband test, one degree step and clamp
module lbt_axis (
   input  logic [7:0]               angle,
   input  logic [10:0]              val_a,
   input  logic [10:0]              val_b,
   input  logic [9:0]               diff_threshold,
   input  lbt_pkg::limits_type      limits,
   output logic [7:0]               angle_next
);

   logic [10:0]       diff;
   logic signed [9:0] stepped;
   logic signed [9:0] lo_s;
   logic signed [9:0] hi_s;

   always_comb begin
      diff    = (val_a > val_b) ? (val_a - val_b) : (val_b - val_a);
      lo_s    = signed'({2'b00, limits.lo});
      hi_s    = signed'({2'b00, limits.hi});
      // step toward the dimmer side, may leave 0..255 before the clamp
      stepped = (val_a > val_b) ? (signed'({2'b00, angle}) - 10'sd1)
                                : (signed'({2'b00, angle}) + 10'sd1);
      if (diff > {1'b0, diff_threshold}) begin
         if (stepped < lo_s) begin
            angle_next = limits.lo;
         end else if (stepped > hi_s) begin
            angle_next = limits.hi;
         end else begin
            angle_next = stepped[7:0];
         end
      end else begin
         angle_next = angle;
      end
   end

endmodule

// ===== sv/light_balance_tracker_stepper_top.sv =====
// top level of the light balance tracker stepper
// throughput: one item per cycle unless the result channel stalls;
// an input register and a result register separate the two channels,
// and pan, tilt and filter state update in one pass
// reset: synchronous active high, restores registers to defaults, pan 50,
// tilt 90, filter 0, and empties both pipeline registers
module light_balance_tracker_stepper_top (
   input  logic                           clock,
   input  logic                           reset,
   // input item channel
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [9:0]                     req_light_left,
   input  logic [9:0]                     req_light_right,
   input  logic [9:0]                     req_light_top,
   input  logic [9:0]                     req_light_bottom,
   // result item channel
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [7:0]                     rsp_angle_x,
   output logic [7:0]                     rsp_angle_y,
   output logic [12:0]                    rsp_total_light,
   output logic                           rsp_night_mode,
   // configuration write channel
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [lbt_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [lbt_pkg::CSR_DATA_W-1:0]  csr_data
);

   // configuration registers
   logic [9:0]  diff_threshold_ff;
   logic [12:0] night_threshold_ff;
   logic [8:0]  ema_alpha_ff;
   logic [7:0]  x_min_ff;
   logic [7:0]  x_max_ff;
   logic [7:0]  y_min_ff;
   logic [7:0]  y_max_ff;

   // tracking state
   logic [7:0]  pan_ff;
   logic [7:0]  pan_in;
   logic [7:0]  tilt_ff;
   logic [7:0]  tilt_in;
   logic [17:0] filt_ff;
   logic [17:0] filt_in;

   // input register
   logic        in_valid_ff;
   logic [9:0]  left_ff;
   logic [9:0]  right_ff;
   logic [9:0]  top_ff;
   logic [9:0]  bottom_ff;

   // result register
   logic        out_valid_ff;
   logic [7:0]  angle_x_ff;
   logic [7:0]  angle_y_ff;
   logic [12:0] total_ff;
   logic        night_ff;

   // handshake
   logic        out_free;
   logic        advance;
   logic        req_accept;

   // datapath
   logic [10:0] lv;
   logic [10:0] rv;
   logic [10:0] tv;
   logic [10:0] bv;
   logic [12:0] total;
   logic        night;
   logic [7:0]  pan_step;
   logic [7:0]  tilt_step;

   lbt_pkg::limits_type x_limits;
   lbt_pkg::limits_type y_limits;

   // the result register frees up when empty or when its item is taken
   assign out_free   = !out_valid_ff || rsp_ready;
   assign advance    = in_valid_ff && out_free;
   assign req_ready  = !in_valid_ff || out_free;
   assign req_accept = req_valid && req_ready;
   assign csr_ready  = 1'b1;

   // configuration writes, unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         diff_threshold_ff  <= lbt_pkg::RST_DIFF_THRESHOLD;
         night_threshold_ff <= lbt_pkg::RST_NIGHT_THRESHOLD;
         ema_alpha_ff       <= lbt_pkg::RST_EMA_ALPHA;
         x_min_ff           <= lbt_pkg::RST_X_MIN;
         x_max_ff           <= lbt_pkg::RST_X_MAX;
         y_min_ff           <= lbt_pkg::RST_Y_MIN;
         y_max_ff           <= lbt_pkg::RST_Y_MAX;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            lbt_pkg::CSR_DIFF_THRESHOLD:  diff_threshold_ff  <= csr_data[9:0];
            lbt_pkg::CSR_NIGHT_THRESHOLD: night_threshold_ff <= csr_data[12:0];
            lbt_pkg::CSR_EMA_ALPHA:       ema_alpha_ff       <= csr_data[8:0];
            lbt_pkg::CSR_X_MIN:           x_min_ff           <= csr_data[7:0];
            lbt_pkg::CSR_X_MAX:           x_max_ff           <= csr_data[7:0];
            lbt_pkg::CSR_Y_MIN:           y_min_ff           <= csr_data[7:0];
            lbt_pkg::CSR_Y_MAX:           y_max_ff           <= csr_data[7:0];
            default: begin
            end
         endcase
      end
   end

   // input register control
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   // input register payload
   always_ff @(posedge clock) begin
      if (req_accept) begin
         left_ff   <= req_light_left;
         right_ff  <= req_light_right;
         top_ff    <= req_light_top;
         bottom_ff <= req_light_bottom;
      end
   end

   // bottom filter, runs on every item, night or not
   lbt_ema u_ema (
      .alpha     (ema_alpha_ff),
      .sample    (bottom_ff),
      .filt      (filt_ff),
      .filt_next (filt_in)
   );

   // offset-corrected readings and their sum
   always_comb begin
      lv    = 11'(left_ff) + lbt_pkg::OFFS_LEFT;
      rv    = 11'(right_ff) + lbt_pkg::OFFS_RIGHT;
      tv    = 11'(top_ff) + lbt_pkg::OFFS_TOP;
      bv    = 11'(filt_in[17:8]) + lbt_pkg::OFFS_BOTTOM;
      total = 13'(lv) + 13'(rv) + 13'(tv) + 13'(bv);
      night = total < night_threshold_ff;
   end

   assign x_limits = '{lo: x_min_ff, hi: x_max_ff};
   assign y_limits = '{lo: y_min_ff, hi: y_max_ff};

   // horizontal axis, decreases when left is brighter
   lbt_axis u_axis_x (
      .angle          (pan_ff),
      .val_a          (lv),
      .val_b          (rv),
      .diff_threshold (diff_threshold_ff),
      .limits         (x_limits),
      .angle_next     (pan_step)
   );

   // vertical axis, decreases when top is brighter
   lbt_axis u_axis_y (
      .angle          (tilt_ff),
      .val_a          (tv),
      .val_b          (bv),
      .diff_threshold (diff_threshold_ff),
      .limits         (y_limits),
      .angle_next     (tilt_step)
   );

   // night parks at the rest position without limits
   assign pan_in  = night ? lbt_pkg::REST_X : pan_step;
   assign tilt_in = night ? lbt_pkg::REST_Y : tilt_step;

   // tracking state advances once per item
   always_ff @(posedge clock) begin
      if (reset) begin
         pan_ff  <= lbt_pkg::RST_PAN;
         tilt_ff <= lbt_pkg::RST_TILT;
         filt_ff <= '0;
      end else if (advance) begin
         pan_ff  <= pan_in;
         tilt_ff <= tilt_in;
         filt_ff <= filt_in;
      end
   end

   // result register control
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   // result register payload
   always_ff @(posedge clock) begin
      if (advance) begin
         angle_x_ff <= pan_in;
         angle_y_ff <= tilt_in;
         total_ff   <= total;
         night_ff   <= night;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_angle_x     = angle_x_ff;
   assign rsp_angle_y     = angle_y_ff;
   assign rsp_total_light = total_ff;
   assign rsp_night_mode  = night_ff;

endmodule

// ===== tb/sv/light_balance_tracker_stepper_checker.sv =====
// scoreboard with its own tracker predictor, watching all three channels
module light_balance_tracker_stepper_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_ready,
   input  logic [9:0]                      req_light_left,
   input  logic [9:0]                      req_light_right,
   input  logic [9:0]                      req_light_top,
   input  logic [9:0]                      req_light_bottom,
   input  logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  logic [7:0]                      rsp_angle_x,
   input  logic [7:0]                      rsp_angle_y,
   input  logic [12:0]                     rsp_total_light,
   input  logic                            rsp_night_mode,
   input  logic                            csr_valid,
   input  logic                            csr_ready,
   input  logic [lbt_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [lbt_pkg::CSR_DATA_W-1:0]  csr_data,
   output int                              fail_count,
   output int                              pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [7:0]  angle_x;
      logic [7:0]  angle_y;
      logic [12:0] total_light;
      logic        night_mode;
   } aim_type;

   // register copies
   logic [9:0]  deadband;
   logic [12:0] night_level;
   logic [8:0]  alpha;
   logic [7:0]  x_lo, x_hi, y_lo, y_hi;

   // tracker state
   logic [7:0]  pan, tilt;
   logic [17:0] bottom_ema;

   aim_type aim_queue[$];
   int      errors = 0;
   int      depth = 0;

   assign fail_count = errors;
   assign pending    = depth;

   function automatic logic [7:0] steer_axis(logic [7:0] angle, int first, int second,
                                             logic [7:0] lo, logic [7:0] hi);
      int spread;
      int moved;
      spread = (first > second) ? first - second : second - first;
      if (spread <= int'(deadband))
         return angle;
      // brighter first side turns the axis down
      moved = (first > second) ? int'(angle) - 1 : int'(angle) + 1;
      if (moved < int'(lo))
         moved = int'(lo);
      else if (moved > int'(hi))
         moved = int'(hi);
      return 8'(moved);
   endfunction

   function automatic aim_type track_sun(logic [9:0] l, logic [9:0] r, logic [9:0] t,
                                         logic [9:0] b);
      int unsigned w;
      int          lv, rv, tv, bv, total;
      aim_type     aim;
      w = 32'((alpha > lbt_pkg::ALPHA_ONE) ? lbt_pkg::ALPHA_ONE : alpha);
      // q10.8 low-pass, truncated
      bottom_ema = 18'((w * b * 32'd256 + (32'd256 - w) * bottom_ema) >> 8);
      lv = int'(l) + int'(lbt_pkg::OFFS_LEFT);
      rv = int'(r) + int'(lbt_pkg::OFFS_RIGHT);
      tv = int'(t) + int'(lbt_pkg::OFFS_TOP);
      bv = int'(bottom_ema[17:8]) + int'(lbt_pkg::OFFS_BOTTOM);
      total = lv + rv + tv + bv;
      aim.night_mode = (total < int'(night_level));
      if (aim.night_mode) begin
         pan  = lbt_pkg::REST_X;
         tilt = lbt_pkg::REST_Y;
      end else begin
         pan  = steer_axis(pan, lv, rv, x_lo, x_hi);
         tilt = steer_axis(tilt, tv, bv, y_lo, y_hi);
      end
      aim.angle_x     = pan;
      aim.angle_y     = tilt;
      aim.total_light = 13'(total);
      return aim;
   endfunction

   function automatic void check_field(string what, logic [12:0] want, logic [12:0] got);
      if (got !== want) begin
         errors++;
         $display("%0t: %s expected %0d got %0d", $time, what, want, got);
      end
   endfunction

   always @(posedge clock) begin : watch
      aim_type want;
      if (reset) begin
         deadband    = lbt_pkg::RST_DIFF_THRESHOLD;
         night_level = lbt_pkg::RST_NIGHT_THRESHOLD;
         alpha       = lbt_pkg::RST_EMA_ALPHA;
         x_lo        = lbt_pkg::RST_X_MIN;
         x_hi        = lbt_pkg::RST_X_MAX;
         y_lo        = lbt_pkg::RST_Y_MIN;
         y_hi        = lbt_pkg::RST_Y_MAX;
         pan         = lbt_pkg::RST_PAN;
         tilt        = lbt_pkg::RST_TILT;
         bottom_ema  = '0;
         aim_queue.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               lbt_pkg::CSR_DIFF_THRESHOLD:  deadband    = csr_data[9:0];
               lbt_pkg::CSR_NIGHT_THRESHOLD: night_level = csr_data[12:0];
               lbt_pkg::CSR_EMA_ALPHA:       alpha       = csr_data[8:0];
               lbt_pkg::CSR_X_MIN:           x_lo        = csr_data[7:0];
               lbt_pkg::CSR_X_MAX:           x_hi        = csr_data[7:0];
               lbt_pkg::CSR_Y_MIN:           y_lo        = csr_data[7:0];
               lbt_pkg::CSR_Y_MAX:           y_hi        = csr_data[7:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            aim_queue.push_back(track_sun(req_light_left, req_light_right,
                                          req_light_top, req_light_bottom));
         if (rsp_valid && rsp_ready) begin
            if (aim_queue.size() == 0) begin
               errors++;
               $display("%0t: unexpected result x %0d y %0d total %0d night %0d", $time,
                        rsp_angle_x, rsp_angle_y, rsp_total_light, rsp_night_mode);
            end else begin
               want = aim_queue.pop_front();
               check_field("angle_x", 13'(want.angle_x), 13'(rsp_angle_x));
               check_field("angle_y", 13'(want.angle_y), 13'(rsp_angle_y));
               check_field("total_light", want.total_light, rsp_total_light);
               check_field("night_mode", 13'(want.night_mode), 13'(rsp_night_mode));
            end
         end
      end
      depth <= aim_queue.size();
   end

endmodule

// ===== tb/sv/tb_light_balance_tracker_stepper_top.sv =====
// testbench top: clock, reset, stimulus, receiver and verdict for the tracker
module tb_light_balance_tracker_stepper_top ();
   timeunit 1ns;
   timeprecision 1ps;

   // unmapped register index, writes to it must be ignored
   localparam logic [2:0] CSR_SPARE = 3'd7;

   localparam int RANDOM_PHASES   = 9;
   localparam int ITEMS_PER_PHASE = 205;
   localparam int HOLD_CYCLES     = 300;
   localparam int CYCLE_LIMIT     = 300000;

   localparam int         IDLE_PCTS [3] = '{0, 10, 35};
   localparam logic [9:0] RAILS [4]     = '{10'd0, 10'd1, 10'd1022, 10'd1023};

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_ready;
   logic [9:0]                      req_light_left = '0;
   logic [9:0]                      req_light_right = '0;
   logic [9:0]                      req_light_top = '0;
   logic [9:0]                      req_light_bottom = '0;
   logic                            rsp_valid;
   logic                            rsp_ready = 1'b0;
   logic [7:0]                      rsp_angle_x;
   logic [7:0]                      rsp_angle_y;
   logic [12:0]                     rsp_total_light;
   logic                            rsp_night_mode;
   logic                            csr_valid = 1'b0;
   logic                            csr_ready;
   logic [lbt_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [lbt_pkg::CSR_DATA_W-1:0]  csr_data = '0;

   int fail_count;
   int pending;

   // idle odds in percent per item, changed per phase
   int send_idle_pct = 0;
   int rsp_idle_pct  = 0;
   // raised by stimulus, cleared by the receiver once the long hold is over
   bit hold_rsp_long = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   light_balance_tracker_stepper_top u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_light_left   (req_light_left),
      .req_light_right  (req_light_right),
      .req_light_top    (req_light_top),
      .req_light_bottom (req_light_bottom),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_angle_x      (rsp_angle_x),
      .rsp_angle_y      (rsp_angle_y),
      .rsp_total_light  (rsp_total_light),
      .rsp_night_mode   (rsp_night_mode),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   light_balance_tracker_stepper_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_light_left   (req_light_left),
      .req_light_right  (req_light_right),
      .req_light_top    (req_light_top),
      .req_light_bottom (req_light_bottom),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_angle_x      (rsp_angle_x),
      .rsp_angle_y      (rsp_angle_y),
      .rsp_total_light  (rsp_total_light),
      .rsp_night_mode   (rsp_night_mode),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .fail_count       (fail_count),
      .pending          (pending)
   );

   function automatic logic [9:0] clip10(int v);
      if (v < 0)
         return 10'd0;
      if (v > 1023)
         return 10'd1023;
      return 10'(v);
   endfunction

   // now and then set bits above the register width, the block must drop them
   function automatic logic [12:0] stray_bits(int width);
      if ($urandom_range(0, 3) != 0)
         return '0;
      return (13'h1FFF << width) & 13'($urandom);
   endfunction

   // one item on the input channel, with an optional idle burst ahead of it
   task automatic send_lights(input logic [9:0] l, input logic [9:0] r,
                              input logic [9:0] t, input logic [9:0] b);
      @(negedge clock);
      if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_light_left   <= l;
      req_light_right  <= r;
      req_light_top    <= t;
      req_light_bottom <= b;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic write_csr(input logic [2:0] idx, input logic [12:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // stop offering items and let every outstanding result drain out
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      // leave some margin once nothing is pending
      repeat (4) @(posedge clock);
   endtask

   task automatic program_csrs(input logic [9:0] dband, input logic [12:0] dusk,
                               input logic [8:0] weight, input logic [7:0] xl,
                               input logic [7:0] xh, input logic [7:0] yl,
                               input logic [7:0] yh);
      write_csr(lbt_pkg::CSR_DIFF_THRESHOLD, 13'(dband) | stray_bits(10));
      write_csr(lbt_pkg::CSR_NIGHT_THRESHOLD, dusk);
      write_csr(lbt_pkg::CSR_EMA_ALPHA, 13'(weight) | stray_bits(9));
      write_csr(lbt_pkg::CSR_X_MIN, 13'(xl) | stray_bits(8));
      write_csr(lbt_pkg::CSR_X_MAX, 13'(xh) | stray_bits(8));
      write_csr(lbt_pkg::CSR_Y_MIN, 13'(yl) | stray_bits(8));
      write_csr(lbt_pkg::CSR_Y_MAX, 13'(yh) | stray_bits(8));
   endtask

   // receiver: random ready bursts, plus one long hold that backs up the block
   initial begin : rsp_side
      forever begin
         @(negedge clock);
         if (hold_rsp_long) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_rsp_long = 1'b0;
         end else if (rsp_idle_pct > 0 && $urandom_range(0, 99) < rsp_idle_pct) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   // hard stop in case the block hangs
   initial begin : watchdog
      int unsigned cycle_count;
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin : stimulus
      logic [9:0]  l, r, t, b;
      logic [9:0]  base, bottom_hold;
      logic [9:0]  db;
      logic [12:0] nl;
      logic [8:0]  al;
      logic [7:0]  xl, xh, yl, yh;
      int          dx, dy, lim, mode;

      bottom_hold = 10'd512;
      db          = lbt_pkg::RST_DIFF_THRESHOLD;

      // reset held from the start, released on a falling edge
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed, reset settings: rails, each side brighter, deadband edge
      send_idle_pct = 20;
      rsp_idle_pct  = 20;
      send_lights(10'd0, 10'd0, 10'd0, 10'd0);
      send_lights(10'd1023, 10'd1023, 10'd1023, 10'd1023);
      send_lights(10'd1023, 10'd0, 10'd0, 10'd0);
      send_lights(10'd0, 10'd1023, 10'd0, 10'd0);
      send_lights(10'd0, 10'd0, 10'd1023, 10'd0);
      send_lights(10'd0, 10'd0, 10'd0, 10'd1023);
      // corrected left-right difference exactly at the deadband, no step
      send_lights(10'd103, 10'd100, 10'd500, 10'd500);
      // one past the deadband, steps
      send_lights(10'd104, 10'd100, 10'd500, 10'd500);
      // corrected values equal
      send_lights(10'd100, 10'd102, 10'd500, 10'd500);

      // night threshold at the largest possible total, alpha saturated
      settle();
      write_csr(CSR_SPARE, 13'h1FFF);
      program_csrs(10'd0, 13'd4394, 9'd511, 8'd0, 8'd180, 8'd0, 8'd180);
      send_lights(10'd0, 10'd0, 10'd0, 10'd0);
      // total lands exactly on the threshold, so daytime
      send_lights(10'd1023, 10'd1023, 10'd1023, 10'd1023);

      // never night, inverted x limits, wide y limits, filter follows input
      settle();
      program_csrs(10'd0, 13'd0, 9'd256, 8'd200, 8'd100, 8'd0, 8'd255);
      send_lights(10'd1023, 10'd0, 10'd0, 10'd1023);
      send_lights(10'd0, 10'd1023, 10'd0, 10'd1023);
      send_lights(10'd1023, 10'd0, 10'd0, 10'd1023);
      send_lights(10'd0, 10'd0, 10'd1023, 10'd0);
      // both axes balanced with zero deadband
      send_lights(10'd100, 10'd102, 10'd100, 10'd20);

      // filter frozen, pinned limits at the bottom and top of the register
      settle();
      program_csrs(10'd0, 13'd0, 9'd0, 8'd0, 8'd0, 8'd255, 8'd255);
      send_lights(10'd1023, 10'd0, 10'd0, 10'd0);
      send_lights(10'd1023, 10'd0, 10'd0, 10'd0);
      send_lights(10'd0, 10'd0, 10'd1023, 10'd0);

      // random phases, each with its own settings and idle odds
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         settle();
         case ($urandom_range(0, 3))
            0:       db = 10'd0;
            1:       db = 10'd1023;
            2:       db = 10'($urandom);
            default: db = 10'($urandom_range(0, 24));
         endcase
         case ($urandom_range(0, 5))
            0:       nl = 13'd0;
            1:       nl = 13'd4394;
            2:       nl = 13'h1FFF;
            3:       nl = 13'($urandom);
            default: nl = 13'($urandom_range(900, 2600));
         endcase
         case ($urandom_range(0, 4))
            0:       al = 9'd0;
            1:       al = lbt_pkg::ALPHA_ONE;
            2:       al = 9'($urandom_range(257, 511));
            3:       al = lbt_pkg::RST_EMA_ALPHA;
            default: al = 9'($urandom_range(0, 256));
         endcase
         case ($urandom_range(0, 4))
            0:       begin xl = 8'd0; xh = 8'd180; end
            1:       begin xl = 8'($urandom); xh = 8'($urandom); end
            2:       begin xl = 8'd0; xh = 8'd255; end
            default: begin xl = 8'($urandom_range(0, 170)); xh = 8'($urandom_range(xl, 180)); end
         endcase
         case ($urandom_range(0, 4))
            0:       begin yl = 8'd0; yh = 8'd180; end
            1:       begin yl = 8'($urandom); yh = 8'($urandom); end
            2:       begin yl = 8'd0; yh = 8'd255; end
            default: begin yl = 8'($urandom_range(0, 170)); yh = 8'($urandom_range(yl, 180)); end
         endcase
         program_csrs(db, nl, al, xl, xh, yl, yh);

         // last phase runs flat out on both sides
         if (phase == RANDOM_PHASES - 1) begin
            send_idle_pct = 0;
            rsp_idle_pct  = 0;
         end else begin
            send_idle_pct = IDLE_PCTS[$urandom_range(0, 2)];
            rsp_idle_pct  = IDLE_PCTS[$urandom_range(0, 2)];
         end

         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            // receiver goes quiet for a long while, sender keeps pushing
            if (phase == 2 && n == 60)
               hold_rsp_long = 1'b1;
            // bottom light holds for stretches so the filter settles
            if ($urandom_range(0, 19) == 0)
               bottom_hold = 10'($urandom);
            mode = $urandom_range(0, 9);
            if (mode < 2) begin
               // anything goes
               l = 10'($urandom);
               r = 10'($urandom);
               t = 10'($urandom);
               b = 10'($urandom);
            end else if (mode == 2) begin
               // rails and near-rails
               l = RAILS[$urandom_range(0, 3)];
               r = RAILS[$urandom_range(0, 3)];
               t = RAILS[$urandom_range(0, 3)];
               b = RAILS[$urandom_range(0, 3)];
            end else begin
               // tracking: corrected differences hover around the deadband
               lim  = int'(db) + 3;
               base = 10'($urandom);
               dx   = int'($urandom_range(0, 2 * lim)) - lim;
               dy   = int'($urandom_range(0, 2 * lim)) - lim;
               r    = base;
               l    = clip10(int'(base) + dx - 2);
               b    = bottom_hold;
               t    = clip10(int'(bottom_hold) + 80 + dy);
            end
            send_lights(l, r, t, b);
         end
      end

      settle();
      if (fail_count == 0 && pending == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
